### rtl/core/imm_pkg.sv
// shared types, constants and helper functions of the integer matrix multiply core
`timescale 1ns / 1ps
`default_nettype none
package imm_pkg;

  localparam int MAX_DIM    = 32;
  localparam int ELEM_WIDTH = 32;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int IDX_W      = 5;
  localparam int VAL_W      = 32;

  localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

  localparam logic [1:0] KIND_WRITE_X = 2'd0;
  localparam logic [1:0] KIND_WRITE_Y = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;
  localparam logic [1:0] KIND_READ_Z  = 2'd3;

  localparam logic REPLY_DONE = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // last index in use for each loop of the product
  typedef struct packed {
    dim_t m_last;
    dim_t n_last;
    dim_t k_last;
  } dims_t;

  // tag that travels with one multiply-accumulate step
  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    addr_t zaddr;
  } mac_tag_t;

  // zero is taken as one, anything above the maximum saturates
  function automatic dim_t dim_last(logic [CFG_W-1:0] v);
    dim_t r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - 6'd1);
    end
    return r;
  endfunction

  function automatic addr_t addr_of(dim_t r, dim_t c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  function automatic elem_t to_elem(logic signed [VAL_W-1:0] v);
    return ELEM_WIDTH'(v);
  endfunction

  function automatic logic [VAL_W-1:0] to_reply(elem_t e);
    return VAL_W'(e);
  endfunction

endpackage
`default_nettype wire

### rtl/core/imm_in_if.sv
// command channel: valid/ready handshake with element write, start and read words
`timescale 1ns / 1ps
`default_nettype none
interface imm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [imm_pkg::IDX_W-1:0]           row;
  logic [imm_pkg::IDX_W-1:0]           col;
  logic signed [imm_pkg::VAL_W-1:0]    value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink (input valid, kind, row, col, value, output ready);
endinterface
`default_nettype wire

### rtl/core/imm_out_if.sv
// reply channel: valid/ready handshake with done and read-data words
`timescale 1ns / 1ps
`default_nettype none
interface imm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                reply_kind;
  logic signed [imm_pkg::VAL_W-1:0]    reply_value;

  modport source (output valid, reply_kind, reply_value, input ready);
  modport sink (input valid, reply_kind, reply_value, output ready);
endinterface
`default_nettype wire

### rtl/core/integer_matrix_multiply_core.sv
// Integer matrix multiply core: Z = X * Y over 32-bit elements held in on-chip ram.
//
// cmd_i takes one word per accepted handshake: write an X element, write a Y
// element, start the product, or read a Z element. rsp_o gives one word per
// start (a done reply with value zero) and one per read (the Z element).
// Sizes m, n and k come from the configuration write port; zero counts as one,
// above 32 saturates. They must be changed only while the core is idle, and Z
// must be read only after a start; the core enforces neither. Element writes
// produce no reply. A read moves the registered Z ram data into the reply
// register. A start walks m*n*k multiply-accumulate steps, one per cycle
// through the x/y ram read port, and the pipeline drains before the done
// reply. The next word is taken once the reply slot is free or being emptied
// and no read is pending, and never during a product. Reset clears the
// control state and sets all sizes to 32; ram contents are undefined until
// written. When rsp_o stalls, the reply is held and cmd_i is not ready.
`timescale 1ns / 1ps
`default_nettype none
module integer_matrix_multiply_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [imm_pkg::CFG_W-1:0]       cfg_data_i,
  imm_in_if.sink                               cmd_i,
  imm_out_if.source                            rsp_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;

  logic [imm_pkg::CFG_W-1:0] rows_m_q, cols_n_q, inner_k_q;
  imm_pkg::dims_t            dims;

  logic                         out_valid_q, out_kind_q;
  logic [imm_pkg::VAL_W-1:0]    out_value_q;
  logic                         rd_pend_q, rd_zero_q;

  logic                 accept, in_range, slot_free;
  imm_pkg::addr_t       host_addr;
  imm_pkg::elem_t       host_elem;
  logic                 start;

  imm_pkg::addr_t       xaddr, yaddr, zwaddr;
  imm_pkg::elem_t       xdata, ydata, zwdata, zrdata;
  imm_pkg::mac_tag_t    tag;
  logic                 seq_busy, mac_busy, zwe;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= imm_pkg::DIM_RESET;
      cols_n_q  <= imm_pkg::DIM_RESET;
      inner_k_q <= imm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imm_pkg::REG_ROWS_M:  rows_m_q  <= cfg_data_i;
        imm_pkg::REG_COLS_N:  cols_n_q  <= cfg_data_i;
        imm_pkg::REG_INNER_K: inner_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dims.m_last = imm_pkg::dim_last(rows_m_q);
  assign dims.n_last = imm_pkg::dim_last(cols_n_q);
  assign dims.k_last = imm_pkg::dim_last(inner_k_q);

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && !rd_pend_q && slot_free;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign in_range  = (32'(cmd_i.row) < imm_pkg::MAX_DIM) &&
                     (32'(cmd_i.col) < imm_pkg::MAX_DIM);
  assign host_addr = imm_pkg::addr_of(imm_pkg::DIM_W'(cmd_i.row),
                                      imm_pkg::DIM_W'(cmd_i.col));
  assign host_elem = imm_pkg::to_elem(cmd_i.value);
  assign start     = accept && (cmd_i.kind == imm_pkg::KIND_START);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_kind_q  <= imm_pkg::REPLY_DONE;
      out_value_q <= '0;
      rd_pend_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q <= 1'b0;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= imm_pkg::REPLY_READ;
        out_value_q <= rd_zero_q ? '0 : imm_pkg::to_reply(zrdata);
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i.kind == imm_pkg::KIND_READ_Z) begin
            rd_pend_q <= 1'b1;
            rd_zero_q <= !in_range;
          end
          if (start) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // product finished once the sequencer and the mac pipeline are empty
          if (!seq_busy && !mac_busy) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_kind_q  <= imm_pkg::REPLY_DONE;
            out_value_q <= '0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.reply_kind  = out_kind_q;
  assign rsp_o.reply_value = out_value_q;

  imm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .dims_i  (dims),
    .xaddr_o (xaddr),
    .yaddr_o (yaddr),
    .tag_o   (tag),
    .busy_o  (seq_busy)
  );

  imm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .x_i     (xdata),
    .y_i     (ydata),
    .zwe_o   (zwe),
    .zaddr_o (zwaddr),
    .zdata_o (zwdata),
    .busy_o  (mac_busy)
  );

  imm_ram #(
    .WIDTH (imm_pkg::ELEM_WIDTH),
    .DEPTH (imm_pkg::DEPTH)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && cmd_i.kind == imm_pkg::KIND_WRITE_X),
    .waddr_i (host_addr),
    .wdata_i (host_elem),
    .raddr_i (xaddr),
    .rdata_o (xdata)
  );

  imm_ram #(
    .WIDTH (imm_pkg::ELEM_WIDTH),
    .DEPTH (imm_pkg::DEPTH)
  ) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && cmd_i.kind == imm_pkg::KIND_WRITE_Y),
    .waddr_i (host_addr),
    .wdata_i (host_elem),
    .raddr_i (yaddr),
    .rdata_o (ydata)
  );

  imm_ram #(
    .WIDTH (imm_pkg::ELEM_WIDTH),
    .DEPTH (imm_pkg::DEPTH)
  ) u_z_ram (
    .clk_i   (clk_i),
    .we_i    (zwe),
    .waddr_i (zwaddr),
    .wdata_i (zwdata),
    .raddr_i (host_addr),
    .rdata_o (zrdata)
  );

endmodule
`default_nettype wire

### rtl/core/imm_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/core/imm_seq.sv
// loop sequencer of the product: walks i, j, l and issues x/y read addresses
`timescale 1ns / 1ps
`default_nettype none
module imm_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire imm_pkg::dims_t    dims_i,
  output imm_pkg::addr_t         xaddr_o,
  output imm_pkg::addr_t         yaddr_o,
  output imm_pkg::mac_tag_t      tag_o,
  output logic                   busy_o
);

  logic          run_q, run_d;
  imm_pkg::dim_t i_q, i_d, j_q, j_d, l_q, l_d;
  logic          l_wrap, j_wrap, i_wrap;

  assign l_wrap = (l_q == dims_i.k_last);
  assign j_wrap = (j_q == dims_i.n_last);
  assign i_wrap = (i_q == dims_i.m_last);

  always_comb begin
    run_d = run_q;
    i_d   = i_q;
    j_d   = j_q;
    l_d   = l_q;
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      j_d   = '0;
      l_d   = '0;
    end else if (run_q) begin
      l_d = l_q + 1'b1;
      if (l_wrap) begin
        l_d = '0;
        j_d = j_q + 1'b1;
        if (j_wrap) begin
          j_d = '0;
          i_d = i_q + 1'b1;
          if (i_wrap) begin
            i_d   = '0;
            run_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      l_q   <= '0;
    end else begin
      run_q <= run_d;
      i_q   <= i_d;
      j_q   <= j_d;
      l_q   <= l_d;
    end
  end

  assign xaddr_o     = imm_pkg::addr_of(i_q, l_q);
  assign yaddr_o     = imm_pkg::addr_of(l_q, j_q);
  assign tag_o.valid = run_q;
  assign tag_o.first = (l_q == '0);
  assign tag_o.last  = l_wrap;
  assign tag_o.zaddr = imm_pkg::addr_of(i_q, j_q);
  assign busy_o      = run_q;

endmodule
`default_nettype wire

### rtl/core/imm_mac.sv
// multiply-accumulate datapath: registered product, accumulator, z write-back
`timescale 1ns / 1ps
`default_nettype none
module imm_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire imm_pkg::mac_tag_t tag_i,
  input  wire imm_pkg::elem_t    x_i,
  input  wire imm_pkg::elem_t    y_i,
  output logic                   zwe_o,
  output imm_pkg::addr_t         zaddr_o,
  output imm_pkg::elem_t         zdata_o,
  output logic                   busy_o
);

  imm_pkg::mac_tag_t tag1_q, tag2_q;
  imm_pkg::elem_t    prod_q, acc_q, sum;

  // tag1 lines up with the ram read data, tag2 with the product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_i * y_i;
    if (tag2_q.valid) begin
      acc_q <= sum;
    end
  end

  assign sum     = (tag2_q.first ? '0 : acc_q) + prod_q;
  assign zwe_o   = tag2_q.valid && tag2_q.last;
  assign zaddr_o = tag2_q.zaddr;
  assign zdata_o = sum;
  assign busy_o  = tag1_q.valid || tag2_q.valid;

endmodule
`default_nettype wire

### bench/tb_integer_matrix_multiply_core.sv
// testbench for the integer matrix multiply core: scoreboard package and top module
`timescale 1ns / 1ps
package gemm_check_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
  } command_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } reply_t;

  class gemm_scoreboard;
    logic [31:0] x_mem [imm_pkg::DEPTH];
    logic [31:0] y_mem [imm_pkg::DEPTH];
    logic [31:0] z_mem [imm_pkg::DEPTH];
    logic [imm_pkg::CFG_W-1:0] rows_reg;
    logic [imm_pkg::CFG_W-1:0] cols_reg;
    logic [imm_pkg::CFG_W-1:0] inner_reg;
    reply_t due [$];
    int mismatches;
    int replies_seen;
    int products;
    int reads;

    function new();
      rows_reg = imm_pkg::DIM_RESET;
      cols_reg = imm_pkg::DIM_RESET;
      inner_reg = imm_pkg::DIM_RESET;
      mismatches = 0;
      replies_seen = 0;
      products = 0;
      reads = 0;
    endfunction

    // zero counts as one, anything above the array size saturates
    static function int size_of(logic [imm_pkg::CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > imm_pkg::MAX_DIM) return imm_pkg::MAX_DIM;
      return int'(v);
    endfunction

    function void set_reg(logic [imm_pkg::CFG_IDX_W-1:0] idx,
                          logic [imm_pkg::CFG_W-1:0] data);
      case (idx)
        imm_pkg::REG_ROWS_M:  rows_reg = data;
        imm_pkg::REG_COLS_N:  cols_reg = data;
        imm_pkg::REG_INNER_K: inner_reg = data;
        default: ;
      endcase
    endfunction

    function void multiply();
      int m;
      int n;
      int k;
      logic [31:0] acc;
      m = size_of(rows_reg);
      n = size_of(cols_reg);
      k = size_of(inner_reg);
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int l = 0; l < k; l++) begin
            acc = acc + x_mem[i * imm_pkg::MAX_DIM + l] * y_mem[l * imm_pkg::MAX_DIM + j];
          end
          z_mem[i * imm_pkg::MAX_DIM + j] = acc;
        end
      end
      products++;
    endfunction

    function void note_command(command_t c);
      int addr;
      reply_t r;
      addr = int'(c.row) * imm_pkg::MAX_DIM + int'(c.col);
      case (c.kind)
        imm_pkg::KIND_WRITE_X: x_mem[addr] = c.value;
        imm_pkg::KIND_WRITE_Y: y_mem[addr] = c.value;
        imm_pkg::KIND_START: begin
          multiply();
          r.kind = imm_pkg::REPLY_DONE;
          r.value = '0;
          due.push_back(r);
        end
        default: begin
          r.kind = imm_pkg::REPLY_READ;
          r.value = z_mem[addr];
          due.push_back(r);
        end
      endcase
    endfunction

    // one line per mismatch
    task report(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_reply(logic kind, logic [31:0] value);
      reply_t e;
      replies_seen++;
      if (due.size() == 0) begin
        report($sformatf("reply word kind %0b value %h with nothing outstanding", kind, value));
        return;
      end
      e = due.pop_front();
      if (e.kind == imm_pkg::REPLY_READ) reads++;
      if (kind !== e.kind) report($sformatf("reply kind %b, expected %b", kind, e.kind));
      if (value !== e.value) begin
        report($sformatf("reply value %h, expected %h (kind %b)", value, e.value, e.kind));
      end
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

module tb_integer_matrix_multiply_core;
  import imm_pkg::*;
  import gemm_check_pkg::*;

  localparam int ITEM_TARGET = 1875;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIM = MAX_DIM;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  imm_in_if cmd ();
  imm_out_if rsp ();

  integer_matrix_multiply_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd),
    .rsp_o      (rsp)
  );

  gemm_scoreboard sb = new();

  // which entries hold data, so no product or read ever touches an unwritten one
  bit x_set [DEPTH];
  bit y_set [DEPTH];
  bit z_set [DEPTH];
  int cur_m = 32;
  int cur_n = 32;
  int cur_k = 32;
  int items_sent = 0;
  int size_settings = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      sb.check_reply(rsp.reply_kind, rsp.reply_value);
    end
  end

  // reply side: random stalls, one long hold-off, and a stretch that never stalls
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready = 1'b0;
      end else if (!hold_done && sb.replies_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 300;
        rsp.ready = 1'b0;
      end else if (sb.replies_seen >= 250 && sb.replies_seen < 450) begin
        rsp.ready = 1'b1;
      end else begin
        rsp.ready = ($urandom_range(0, 99) >= 8);
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(int top);
    if ($urandom_range(0, 9) == 0) return '0;
    return CFG_W'($urandom_range(1, top));
  endfunction

  function automatic logic [CFG_W-1:0] pick_big();
    if ($urandom_range(0, 1) == 1) return CFG_W'(32);
    return CFG_W'($urandom_range(33, 63));
  endfunction

  function automatic bit region_ready();
    for (int i = 0; i < cur_m; i++) begin
      for (int l = 0; l < cur_k; l++) begin
        if (!x_set[i * DIM + l]) return 1'b0;
      end
    end
    for (int l = 0; l < cur_k; l++) begin
      for (int j = 0; j < cur_n; j++) begin
        if (!y_set[l * DIM + j]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // every task of this module starts and returns just after a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [4:0] row,
                           input logic [4:0] col, input logic [31:0] value);
    command_t c;
    bit no_gaps;
    no_gaps = (items_sent >= 800 && items_sent < 1100);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    c.kind = kind;
    c.row = row;
    c.col = col;
    c.value = value;
    cmd.valid = 1'b1;
    cmd.kind = kind;
    cmd.row = row;
    cmd.col = col;
    cmd.value = value;
    @(posedge clk);
    while (cmd.ready !== 1'b1) @(posedge clk);
    sb.note_command(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_x(input int r, input int c, input logic [31:0] v);
    x_set[r * DIM + c] = 1'b1;
    send_item(KIND_WRITE_X, 5'(r), 5'(c), v);
  endtask

  task automatic write_y(input int r, input int c, input logic [31:0] v);
    y_set[r * DIM + c] = 1'b1;
    send_item(KIND_WRITE_Y, 5'(r), 5'(c), v);
  endtask

  task automatic read_z(input int r, input int c);
    send_item(KIND_READ_Z, 5'(r), 5'(c), $urandom());
  endtask

  task automatic start_product();
    send_item(KIND_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), $urandom());
    for (int i = 0; i < cur_m; i++) begin
      for (int j = 0; j < cur_n; j++) z_set[i * DIM + j] = 1'b1;
    end
  endtask

  task automatic noise_write();
    if ($urandom_range(0, 1) == 1) begin
      write_x($urandom_range(0, 31), $urandom_range(0, 31), rand_value());
    end else begin
      write_y($urandom_range(0, 31), $urandom_range(0, 31), rand_value());
    end
  endtask

  // wait for the last reply, then let any trailing element write retire
  task automatic settle();
    cmd.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] rm, input logic [CFG_W-1:0] rn,
                             input logic [CFG_W-1:0] rk);
    logic [CFG_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0] regs [3];
    vals[0] = rm;
    vals[1] = rn;
    vals[2] = rk;
    regs[0] = REG_ROWS_M;
    regs[1] = REG_COLS_N;
    regs[2] = REG_INNER_K;
    for (int i = 0; i < 3; i++) begin
      cfg_we = 1'b1;
      cfg_idx = regs[i];
      cfg_data = vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
    cur_m = gemm_scoreboard::size_of(rm);
    cur_n = gemm_scoreboard::size_of(rn);
    cur_k = gemm_scoreboard::size_of(rk);
    size_settings++;
  endtask

  // partial refill only happens once the whole region already holds data
  task automatic fill_region(input bit partial);
    for (int i = 0; i < cur_m; i++) begin
      for (int l = 0; l < cur_k; l++) begin
        if ($urandom_range(0, 19) == 0) noise_write();
        if (!partial || $urandom_range(0, 3) == 0) write_x(i, l, rand_value());
      end
    end
    for (int l = 0; l < cur_k; l++) begin
      for (int j = 0; j < cur_n; j++) begin
        if ($urandom_range(0, 19) == 0) noise_write();
        if (!partial || $urandom_range(0, 3) == 0) write_y(l, j, rand_value());
      end
    end
  endtask

  task automatic read_back(input int count);
    int sel;
    int r;
    int c;
    int rr;
    int cc;
    for (int q = 0; q < count; q++) begin
      sel = $urandom_range(0, 19);
      if (sel >= 18) begin
        noise_write();
      end else begin
        r = $urandom_range(0, cur_m - 1);
        c = $urandom_range(0, cur_n - 1);
        if (sel >= 15) begin
          // any word a product has written, often a stale one left by an earlier, larger product
          for (int tries = 0; tries < 8; tries++) begin
            rr = $urandom_range(0, 31);
            cc = $urandom_range(0, 31);
            if (z_set[rr * DIM + cc]) begin
              r = rr;
              c = cc;
              break;
            end
          end
        end
        read_z(r, c);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rm, input logic [CFG_W-1:0] rn,
                           input logic [CFG_W-1:0] rk);
    bit partial;
    int cells;
    settle();
    write_sizes(rm, rn, rk);
    partial = region_ready() && ($urandom_range(0, 4) == 0);
    fill_region(partial);
    start_product();
    cells = (cur_m * cur_n > 24) ? 24 : cur_m * cur_n;
    read_back(cells + $urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0) begin
      fill_region(1'b1);
      start_product();
      read_back($urandom_range(1, cells));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rm;
    logic [CFG_W-1:0] rn;
    logic [CFG_W-1:0] rk;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.kind = KIND_WRITE_X;
    cmd.row = '0;
    cmd.col = '0;
    cmd.value = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single elements: products that wrap, the most negative value, back-to-back starts
    write_sizes(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    write_x(0, 0, 32'h7fff_ffff);
    write_y(0, 0, 32'h7fff_ffff);
    start_product();
    read_z(0, 0);
    write_x(0, 0, 32'h8000_0000);
    write_y(0, 0, 32'hffff_ffff);
    start_product();
    start_product();
    read_z(0, 0);
    write_x(31, 31, 32'h0);
    write_y(31, 31, 32'hffff_ffff);

    // 2x2 accumulation with extreme operands
    settle();
    write_sizes(CFG_W'(2), CFG_W'(2), CFG_W'(2));
    write_x(0, 0, 32'h8000_0000);
    write_x(0, 1, 32'hffff_ffff);
    write_x(1, 0, 32'h7fff_ffff);
    write_x(1, 1, 32'd3);
    write_y(0, 0, 32'h7fff_ffff);
    write_y(0, 1, 32'h8000_0000);
    write_y(1, 0, 32'hffff_ffff);
    write_y(1, 1, 32'h1234_5678);
    start_product();
    read_z(0, 0);
    read_z(0, 1);
    read_z(1, 0);
    read_z(1, 1);

    // saturating and zero sizes, then the full inner dimension
    run_phase(CFG_W'(63), CFG_W'(32), CFG_W'(0));
    read_z(31, 31);
    run_phase(CFG_W'(1), CFG_W'(2), CFG_W'(32));

    while (items_sent < ITEM_TARGET) begin
      rm = pick_size(6);
      rn = pick_size(6);
      rk = pick_size(6);
      if ($urandom_range(0, 9) == 0) begin
        rm = pick_size(3);
        rn = pick_size(3);
        rk = pick_size(3);
        case ($urandom_range(0, 2))
          0: rm = pick_big();
          1: rn = pick_big();
          default: rk = pick_big();
        endcase
      end
      run_phase(rm, rn, rk);
    end

    cmd.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run covered %0d command words over %0d size settings and %0d products",
             items_sent, size_settings, sb.products);
    $display("%0d reply words checked, %0d of them element reads, %0d errors",
             sb.replies_seen, sb.reads, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/imm_pkg.sv
rtl/core/imm_in_if.sv
rtl/core/imm_out_if.sv
rtl/core/imm_ram.sv
rtl/core/imm_seq.sv
rtl/core/imm_mac.sv
rtl/core/integer_matrix_multiply_core.sv
bench/tb_integer_matrix_multiply_core.sv
